@@ sv/txpwc_pkg.sv @@
package txpwc_pkg;

    localparam int BANDS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [2:0] REG_TARGET_POWER = 3'd0;
    localparam logic [2:0] REG_TOLERANCE = 3'd1;
    localparam logic [2:0] REG_SLOPE = 3'd2;
    localparam logic [2:0] REG_BEGIN_WORD = 3'd3;
    localparam logic [2:0] REG_WIDE_LIMIT = 3'd4;
    localparam logic [2:0] REG_MAX_RETRY = 3'd5;
    localparam logic [2:0] REG_SETTLE_COUNT = 3'd6;

    localparam logic [2:0] ST_WAIT = 3'd0;
    localparam logic [2:0] ST_ADJ = 3'd1;
    localparam logic [2:0] ST_PASS = 3'd2;
    localparam logic [2:0] ST_LOW = 3'd3;
    localparam logic [2:0] ST_HIGH = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [1:0] PA_MODE_HIGH = 2'd0;
    localparam logic [1:0] PA_MODE_MID = 2'd1;
    localparam logic [1:0] PA_MODE_LOW = 2'd2;

    localparam logic [9:0] LIMIT_NARROW = 10'h270;
    localparam logic [9:0] LIMIT_WIDE = 10'h294;
    localparam logic [9:0] WORD_MAX = 10'h3ff;
    localparam logic signed [15:0] PA_SPLIT_POWER = 16'sd2560;
    localparam logic signed [24:0] ROUND_BIAS = 25'sd128;

    localparam logic signed [15:0] RST_TARGET_POWER = 16'sd5120;
    localparam logic [11:0] RST_TOLERANCE = 12'd128;
    localparam logic [5:0] RST_SLOPE = 6'd8;
    localparam logic [9:0] RST_BEGIN_WORD = 10'd200;
    localparam logic RST_WIDE_LIMIT = 1'b0;
    localparam logic [5:0] RST_MAX_RETRY = 6'd30;
    localparam logic [5:0] RST_SETTLE_COUNT = 6'd5;

    typedef struct packed {
        logic [3:0] band_index;
        logic signed [15:0] measured_power;
        logic [5:0] retry_count;
    } in_word_t;

    typedef struct packed {
        logic [3:0] band_out;
        logic [2:0] status;
        logic [9:0] power_word;
        logic [11:0] packed_word;
    } out_word_t;

    typedef struct packed {
        logic signed [15:0] target_power;
        logic [11:0] tolerance;
        logic [5:0] slope;
        logic [9:0] begin_word;
        logic wide_limit;
        logic [5:0] max_retry;
        logic [5:0] settle_count;
    } cfg_t;

    typedef struct packed {
        logic [3:0] band;
        logic band_ok;
        logic settling;
        logic is_low;
        logic is_high;
        logic at_max;
        logic signed [24:0] delta;
    } job_t;

endpackage

@@ sv/txpwc_fifo.sv @@
module txpwc_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/txpwc_front.sv @@
module txpwc_front #(
    parameter int NUM_BANDS = 16
) (
    input  txpwc_pkg::in_word_t item,
    input  txpwc_pkg::cfg_t     cfg,
    output txpwc_pkg::job_t     job
);
    import txpwc_pkg::*;

    logic signed [16:0] power_x;
    logic signed [16:0] target_x;
    logic signed [16:0] tol_x;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic signed [16:0] err;
    logic signed [23:0] prod;

    always_comb
    begin
        power_x = 17'(item.measured_power);
        target_x = 17'(cfg.target_power);
        tol_x = $signed({5'b0, cfg.tolerance});
        lo = target_x - tol_x;
        hi = target_x + tol_x;
        err = target_x - power_x;
        prod = 24'($signed({1'b0, cfg.slope})) * 24'(err);

        job.band = item.band_index;
        job.band_ok = (int'(item.band_index) < NUM_BANDS);
        job.settling = (item.retry_count < cfg.settle_count);
        job.is_low = (power_x < lo);
        job.is_high = (power_x > hi);
        job.at_max = (item.retry_count == cfg.max_retry);
        job.delta = ROUND_BIAS - 25'(prod);
    end

endmodule

@@ sv/txpwc_back.sv @@
module txpwc_back #(
    parameter int NUM_BANDS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  txpwc_pkg::cfg_t      cfg,
    input  txpwc_pkg::job_t      job,
    input  logic                 job_empty,
    output logic                 job_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output txpwc_pkg::out_word_t res
);
    import txpwc_pkg::*;

    localparam int AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic state_reg;
    logic state_next;
    job_t cur_reg;
    logic signed [10:0] offset_mem [NUM_BANDS];
    logic signed [10:0] offset_rd_reg;
    logic [NUM_BANDS-1:0] valid_reg;
    logic [NUM_BANDS-1:0] done_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] cur_addr;
    logic signed [10:0] offset;
    logic signed [11:0] sum;
    logic [9:0] word;
    logic [9:0] limit;
    logic signed [25:0] val;
    logic [17:0] quot;
    logic [9:0] new_word;
    logic signed [10:0] new_offset;
    logic [1:0] pa_mode;
    logic wr_offset;
    logic set_done;

    assign rd_addr = AW'(job.band);
    assign cur_addr = AW'(cur_reg.band);
    assign job_pop = (state_reg == S_IDLE) && !job_empty && !res_full;
    assign res_push = (state_reg == S_CALC);

    always_comb
    begin
        offset = valid_reg[cur_addr] ? offset_rd_reg : '0;
        sum = $signed({2'b0, cfg.begin_word}) + 12'(offset);
        if (sum < 0)
        begin
            word = '0;
        end
        else if (sum > $signed({2'b0, WORD_MAX}))
        begin
            word = WORD_MAX;
        end
        else
        begin
            word = sum[9:0];
        end

        limit = cfg.wide_limit ? LIMIT_WIDE : LIMIT_NARROW;
        val = $signed({8'b0, word, 8'b0}) + 26'(cur_reg.delta);
        quot = val[25:8];
        if (val < 0)
        begin
            new_word = '0;
        end
        else if (quot > {8'b0, limit})
        begin
            new_word = limit;
        end
        else
        begin
            new_word = quot[9:0];
        end
        new_offset = 11'($signed({2'b0, new_word}) - $signed({2'b0, cfg.begin_word}));

        if (cfg.target_power > PA_SPLIT_POWER)
        begin
            pa_mode = PA_MODE_HIGH;
        end
        else if (cfg.target_power > 0 && cfg.target_power < PA_SPLIT_POWER)
        begin
            pa_mode = PA_MODE_MID;
        end
        else
        begin
            pa_mode = PA_MODE_LOW;
        end

        res.band_out = cur_reg.band;
        res.status = ST_WAIT;
        res.power_word = word;
        res.packed_word = '0;
        wr_offset = 1'b0;
        set_done = 1'b0;
        if (!cur_reg.band_ok)
        begin
            res.power_word = '0;
        end
        else if (cur_reg.settling)
        begin
            res.status = ST_WAIT;
        end
        else if (done_reg[cur_addr])
        begin
            res.status = ST_DONE;
        end
        else if (!cur_reg.is_low && !cur_reg.is_high)
        begin
            res.status = ST_PASS;
            res.packed_word = {pa_mode, word};
            set_done = 1'b1;
        end
        else if (cur_reg.is_low && (cur_reg.at_max || word == '0))
        begin
            res.status = ST_LOW;
        end
        else if (cur_reg.is_high && (cur_reg.at_max || word == limit))
        begin
            res.status = ST_HIGH;
        end
        else
        begin
            res.status = ST_ADJ;
            res.power_word = new_word;
            wr_offset = 1'b1;
        end

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_pop)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_push && wr_offset)
            begin
                valid_reg[cur_addr] <= 1'b1;
            end
            if (res_push && set_done)
            begin
                done_reg[cur_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
            offset_rd_reg <= offset_mem[rd_addr];
        end
        if (res_push && wr_offset)
        begin
            offset_mem[cur_addr] <= new_offset;
        end
    end

endmodule

@@ sv/tx_power_word_calibration_loop_unit.sv @@
// Channel   Direction  Handshake              Carries
// item      in         push / full            band_index, measured_power, retry_count
// result    out        pop / empty            band_out, status, power_word, packed_word
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// In the back end, the idle state reads the band's stored word offset as it takes a word;
// the calc state computes the word and may write a new offset back. No new word is taken
// before the last is done; a word passes the job queue, job register and result queue.
// Reset clears all bands to the begin word and not done, and restores register defaults.
// Either side may stall; QUEUE_DEPTH-entry queues (two by default) sit between front, back and output.
module tx_power_word_calibration_loop_unit #(
    parameter int NUM_BANDS = txpwc_pkg::BANDS_DEFAULT,
    parameter int QUEUE_DEPTH = txpwc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  txpwc_pkg::in_word_t  item,
    input  logic                 pop,
    output logic                 empty,
    output txpwc_pkg::out_word_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import txpwc_pkg::*;

    cfg_t cfg_reg;
    job_t job_in;
    job_t job_out;
    logic job_empty;
    logic job_pop;
    logic res_full;
    logic res_push;
    out_word_t res_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_power <= RST_TARGET_POWER;
            cfg_reg.tolerance <= RST_TOLERANCE;
            cfg_reg.slope <= RST_SLOPE;
            cfg_reg.begin_word <= RST_BEGIN_WORD;
            cfg_reg.wide_limit <= RST_WIDE_LIMIT;
            cfg_reg.max_retry <= RST_MAX_RETRY;
            cfg_reg.settle_count <= RST_SETTLE_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TARGET_POWER: cfg_reg.target_power <= $signed(cfg_data);
                REG_TOLERANCE: cfg_reg.tolerance <= cfg_data[11:0];
                REG_SLOPE: cfg_reg.slope <= cfg_data[5:0];
                REG_BEGIN_WORD: cfg_reg.begin_word <= cfg_data[9:0];
                REG_WIDE_LIMIT: cfg_reg.wide_limit <= cfg_data[0];
                REG_MAX_RETRY: cfg_reg.max_retry <= cfg_data[5:0];
                REG_SETTLE_COUNT: cfg_reg.settle_count <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    txpwc_front #(
        .NUM_BANDS(NUM_BANDS)
    ) u_front (
        .item(item),
        .cfg (cfg_reg),
        .job (job_in)
    );

    txpwc_fifo #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH($bits(job_t))
    ) u_job_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(job_in),
        .full (full),
        .pop  (job_pop),
        .rdata(job_out),
        .empty(job_empty)
    );

    txpwc_back #(
        .NUM_BANDS(NUM_BANDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .job      (job_out),
        .job_empty(job_empty),
        .job_pop  (job_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_word)
    );

    txpwc_fifo #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH($bits(out_word_t))
    ) u_res_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_word),
        .full (res_full),
        .pop  (pop),
        .rdata(result),
        .empty(empty)
    );

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("Result pushed into a full queue.");

    a_one_job_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> !job_pop && res_push)
        else $error("Back end took a new word before finishing the last one.");

    a_packed_only_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_word.status != ST_PASS) |-> res_word.packed_word == '0)
        else $error("Packed word set on a result that did not pass.");

endmodule
